[rtl/cam_pkg.sv]
// Shared types, field widths, register codes and cosine table math for the AM demodulator.
package cam_pkg;

	typedef longint unsigned u64_t;

	// Field and register widths.
	localparam int SAMPLE_W   = 16;
	localparam int INDEX_W    = 32;
	localparam int AVG_W      = 16;
	localparam int DEM_W      = 18;
	localparam int PHASE_W    = 32;
	localparam int AMP_W      = 15;
	localparam int TAPS_W     = 7;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam int COS_MAG_W  = 15;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CARRIER_TAPS = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_TAPS  = 8'd3;

	// Register values after reset.
	localparam logic [PHASE_W-1:0] PHASE_STEP_RST   = 32'd429496730;
	localparam logic [AMP_W-1:0]   AMPLITUDE_RST    = 15'd10240;
	localparam logic [TAPS_W-1:0]  CARRIER_TAPS_RST = 7'd5;
	localparam logic [TAPS_W-1:0]  SMOOTH_TAPS_RST  = 7'd11;

	// Cosine series constants: pi/2 and one in Q30, and the factorial step divisors.
	localparam u64_t HALF_PI_Q30 = 64'd1686629713;
	localparam u64_t ONE_Q30     = 64'd1073741824;
	localparam u64_t HALF_Q30    = 64'd536870912;
	localparam u64_t COS_SCALE   = 64'd32767;
	localparam int   TERMS       = 8;
	localparam u64_t TAYLOR_DIV [TERMS] = '{64'd2, 64'd12, 64'd30, 64'd56,
		64'd90, 64'd132, 64'd182, 64'd240};

	// First-quadrant cosine entry r of a table with 2^(abits-2) entries per quarter.
	// Evaluated only at elaboration to build the constant table.
	function automatic logic [COS_MAG_W-1:0] cos_quarter(input int r, input int abits);
		u64_t th;
		u64_t t2;
		u64_t term;
		u64_t res;
		longint acc;
		th = (HALF_PI_Q30 * u64_t'(r)) >> (abits - 2);
		t2 = (th * th) >> 30;
		term = ONE_Q30;
		acc = longint'(ONE_Q30);
		for (int k = 1; k <= TERMS; k++) begin
			term = ((term * t2) >> 30) / TAYLOR_DIV[k-1];
			if ((k & 1) == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end else if (acc > longint'(ONE_Q30)) begin
			acc = longint'(ONE_Q30);
		end
		res = (u64_t'(acc) * COS_SCALE + HALF_Q30) >> 30;
		return COS_MAG_W'(res);
	endfunction

endpackage

[rtl/cam_if.sv]
// Channel interfaces: sample input, result output and configuration writes.
interface cam_sample_if;
	logic valid;
	logic ready;
	logic signed [cam_pkg::SAMPLE_W-1:0] sample;
	logic [cam_pkg::INDEX_W-1:0] sample_index;

	modport source (output valid, output sample, output sample_index, input ready);
	modport sink (input valid, input sample, input sample_index, output ready);
endinterface

interface cam_result_if;
	logic valid;
	logic ready;
	logic signed [cam_pkg::AVG_W-1:0] baseband_avg;
	logic signed [cam_pkg::DEM_W-1:0] demodulated;

	modport source (output valid, output baseband_avg, output demodulated, input ready);
	modport sink (input valid, input baseband_avg, input demodulated, output ready);
endinterface

interface cam_cfg_if;
	logic valid;
	logic ready;
	logic [cam_pkg::CFG_IDX_W-1:0] index;
	logic [cam_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/cam_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module cam_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/cam_div.sv]
// Iterative signed-by-unsigned divider, two quotient bits per cycle, truncating toward zero.
module cam_div #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0]        divisor,
	output logic signed [NUM_W-1:0] quotient,
	output logic                    done
);

	localparam int WORK_W = NUM_W + (NUM_W % 2);
	localparam int STEPS  = WORK_W / 2;
	localparam int CNT_W  = $clog2(STEPS + 1);

	logic [DEN_W-1:0]  rem_q;
	logic [WORK_W-1:0] quo_q;
	logic [DEN_W-1:0]  den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              neg_q;
	logic              done_q;

	logic [NUM_W-1:0]  mag;
	logic [DEN_W-1:0]  rem_next;
	logic [WORK_W-1:0] quo_next;
	logic [DEN_W:0]    shifted;
	logic [WORK_W-1:0] quo_neg;

	// Magnitude of the dividend; the most negative value maps onto itself as unsigned.
	assign mag = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);

	// Two restoring division steps per cycle.
	always_comb begin
		rem_next = rem_q;
		quo_next = quo_q;
		shifted = '0;
		for (int i = 0; i < 2; i++) begin
			shifted = {rem_next, quo_next[WORK_W-1]};
			quo_next = {quo_next[WORK_W-2:0], 1'b0};
			if (shifted >= {1'b0, den_q}) begin
				shifted = shifted - {1'b0, den_q};
				quo_next[0] = 1'b1;
			end
			rem_next = shifted[DEN_W-1:0];
		end
	end

	// Control: load on start, count down the steps, flag completion for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= WORK_W'(mag);
			den_q <= divisor;
			neg_q <= dividend[NUM_W-1];
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
		end
	end

	// Restore the sign of the quotient.
	assign quo_neg = -quo_q;
	assign quotient = neg_q ? $signed(NUM_W'(quo_neg)) : $signed(NUM_W'(quo_q));
	assign done = done_q;

endmodule

[rtl/cam_mavg.sv]
// Moving-average line: delay line in RAM with running sum, write position and fill count.
module cam_mavg #(
	parameter int LINE_W   = 16,
	parameter int SUM_W    = 22,
	parameter int MAX_TAPS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [LINE_W-1:0]             x,
	input  logic [cam_pkg::TAPS_W-1:0]           taps,
	output logic signed [SUM_W-1:0]              sum,
	output logic [$clog2(MAX_TAPS+1)-1:0]        count,
	output logic                                 done
);

	localparam int POS_W = $clog2(MAX_TAPS);
	localparam int CNT_W = $clog2(MAX_TAPS + 1);

	logic signed [SUM_W-1:0]  sum_q;
	logic [POS_W-1:0]         pos_q;
	logic [CNT_W-1:0]         count_q;
	logic [MAX_TAPS-1:0]      valid_q;
	logic                     busy_q;
	logic                     done_q;
	logic signed [LINE_W-1:0] x_q;

	logic [LINE_W-1:0]        rdata;
	logic signed [LINE_W-1:0] old_val;
	logic [CNT_W-1:0]         taps_eff;
	logic [CNT_W-1:0]         pos_inc;
	logic [POS_W-1:0]         pos_next;

	// Line storage; the read address follows the write position so the old entry is
	// ready in the cycle after start.
	cam_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_TAPS)
	) u_line (
		.clk  (clk),
		.we   (busy_q),
		.waddr(pos_q),
		.wdata(x_q),
		.raddr(pos_q),
		.rdata(rdata)
	);

	// Tap count in effect: zero acts as one, anything above the line length as the length.
	always_comb begin
		if (taps == '0) begin
			taps_eff = CNT_W'(1);
		end else if (int'(taps) > MAX_TAPS) begin
			taps_eff = CNT_W'(MAX_TAPS);
		end else begin
			taps_eff = CNT_W'(taps);
		end
	end

	// Entries never written since reset read as zero.
	assign old_val = valid_q[pos_q] ? $signed(rdata) : '0;

	// Next write position wraps at the tap count.
	assign pos_inc = CNT_W'(pos_q) + CNT_W'(1);
	assign pos_next = (pos_inc >= taps_eff) ? '0 : POS_W'(pos_inc);

	// Read-modify-write of the line entry and the running sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			pos_q <= '0;
			count_q <= '0;
			valid_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
				sum_q <= sum_q - SUM_W'(old_val) + SUM_W'(x_q);
				valid_q[pos_q] <= 1'b1;
				pos_q <= pos_next;
				if (count_q < taps_eff) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	// Incoming word held for the write-back cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
		end
	end

	assign sum = sum_q;
	assign count = count_q;
	assign done = done_q;

endmodule

[rtl/coherent_am_demodulator_core.sv]
// Coherent AM demodulator: NCO cosine mixer, carrier moving average, scaling, smoothing average.
// Each sample word goes through the mixer, the carrier average and divider, the scaling, and the
// smoothing average and divider; DIV_W = 18 + clog2(MAX_TAPS). A new word is accepted only in idle,
// after the previous result has been pushed; a result left waiting in the output register only
// holds back the next push. Reset restores the register defaults and clears sums, counts,
// positions and line valid bits at once; no clearing pass.
module coherent_am_demodulator_core #(
	parameter int MAX_TAPS      = 64,
	parameter int COS_ADDR_BITS = 10
) (
	input logic          clk,
	input logic          arst_n,
	cam_sample_if.sink   sample_ch,
	cam_result_if.source result_ch,
	cam_cfg_if.sink      cfg
);

	localparam int CAR_W   = cam_pkg::SAMPLE_W + $clog2(MAX_TAPS);
	localparam int SM_W    = cam_pkg::DEM_W + $clog2(MAX_TAPS);
	localparam int DIV_W   = SM_W;
	localparam int CNT_W   = $clog2(MAX_TAPS + 1);
	localparam int QUARTER = 2 ** (COS_ADDR_BITS - 2);
	localparam int QI_W    = COS_ADDR_BITS - 1;
	localparam int REC_W   = cam_pkg::DEM_W + 2;

	localparam logic signed [DIV_W-1:0] AVG_HI = DIV_W'(32767);
	localparam logic signed [DIV_W-1:0] AVG_LO = DIV_W'(-32768);
	localparam logic signed [DIV_W-1:0] DEM_HI = DIV_W'(131071);
	localparam logic signed [DIV_W-1:0] DEM_LO = DIV_W'(-131072);
	localparam logic signed [REC_W-1:0] REC_HI = REC_W'(131071);
	localparam logic signed [REC_W-1:0] REC_LO = REC_W'(-131072);

	// Sequencer states.
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_ROM      = 4'd1;
	localparam logic [3:0] ST_MIX      = 4'd2;
	localparam logic [3:0] ST_CAR_GO   = 4'd3;
	localparam logic [3:0] ST_CAR_WAIT = 4'd4;
	localparam logic [3:0] ST_CAR_DIV  = 4'd5;
	localparam logic [3:0] ST_REC      = 4'd6;
	localparam logic [3:0] ST_SM_GO    = 4'd7;
	localparam logic [3:0] ST_SM_WAIT  = 4'd8;
	localparam logic [3:0] ST_SM_DIV   = 4'd9;
	localparam logic [3:0] ST_PUSH     = 4'd10;

	logic [3:0] state_q;

	// Configuration registers.
	logic [cam_pkg::PHASE_W-1:0] phase_step_q;
	logic [cam_pkg::AMP_W-1:0]   amplitude_q;
	logic [cam_pkg::TAPS_W-1:0]  carrier_taps_q;
	logic [cam_pkg::TAPS_W-1:0]  smooth_taps_q;

	// Datapath registers.
	logic signed [cam_pkg::SAMPLE_W-1:0] sample_q;
	logic [cam_pkg::PHASE_W-1:0]         phase_q;
	logic signed [cam_pkg::SAMPLE_W-1:0] cos_q;
	logic signed [cam_pkg::SAMPLE_W-1:0] mix_q;
	logic signed [cam_pkg::AVG_W-1:0]    avg_q;
	logic signed [cam_pkg::DEM_W-1:0]    rec_q;
	logic signed [cam_pkg::DEM_W-1:0]    dem_q;
	logic                                out_valid_q;
	logic signed [cam_pkg::AVG_W-1:0]    out_avg_q;
	logic signed [cam_pkg::DEM_W-1:0]    out_dem_q;

	logic                              accept;
	logic                              out_free;
	logic [cam_pkg::PHASE_W-1:0]       phase_prod;
	logic [COS_ADDR_BITS-1:0]          rom_addr;
	logic [1:0]                        quad;
	logic [COS_ADDR_BITS-3:0]          rom_off;
	logic [QI_W-1:0]                   rom_idx;
	logic [cam_pkg::COS_MAG_W-1:0]     cos_mag;
	logic signed [cam_pkg::SAMPLE_W-1:0] cos_val;
	logic signed [2*cam_pkg::SAMPLE_W-1:0] mix_prod;
	logic signed [2*cam_pkg::SAMPLE_W-1:0] mix_round;
	logic signed [REC_W-1:0]           rec_wide;

	logic                    car_start;
	logic                    car_done;
	logic signed [CAR_W-1:0] car_sum;
	logic [CNT_W-1:0]        car_count;
	logic                    sm_start;
	logic                    sm_done;
	logic signed [SM_W-1:0]  sm_sum;
	logic [CNT_W-1:0]        sm_count;

	logic                    div_start;
	logic signed [DIV_W-1:0] div_num;
	logic [CNT_W-1:0]        div_den;
	logic signed [DIV_W-1:0] div_quo;
	logic                    div_done;

	logic [cam_pkg::COS_MAG_W-1:0] cos_tab [QUARTER+1];

	// First-quadrant cosine table, built at elaboration.
	for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_cos
		localparam logic [cam_pkg::COS_MAG_W-1:0] ENTRY =
			cam_pkg::cos_quarter(gi, COS_ADDR_BITS);
		assign cos_tab[gi] = ENTRY;
	end

	// Handshakes.
	assign sample_ch.ready = (state_q == ST_IDLE);
	assign accept = sample_ch.valid && sample_ch.ready;
	assign cfg.ready = 1'b1;
	assign out_free = !out_valid_q || result_ch.ready;

	// Configuration register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= cam_pkg::PHASE_STEP_RST;
			amplitude_q <= cam_pkg::AMPLITUDE_RST;
			carrier_taps_q <= cam_pkg::CARRIER_TAPS_RST;
			smooth_taps_q <= cam_pkg::SMOOTH_TAPS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				cam_pkg::REG_PHASE_STEP: begin
					phase_step_q <= cfg.data;
				end
				cam_pkg::REG_AMPLITUDE: begin
					amplitude_q <= cfg.data[cam_pkg::AMP_W-1:0];
				end
				cam_pkg::REG_CARRIER_TAPS: begin
					carrier_taps_q <= cfg.data[cam_pkg::TAPS_W-1:0];
				end
				cam_pkg::REG_SMOOTH_TAPS: begin
					smooth_taps_q <= cfg.data[cam_pkg::TAPS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Phase word: index times step, modulo 2^32.
	assign phase_prod = sample_ch.sample_index * phase_step_q;

	// Cosine lookup with quadrant folding: odd quadrants mirror, middle quadrants negate.
	assign rom_addr = phase_q[cam_pkg::PHASE_W-1 -: COS_ADDR_BITS];
	assign quad = rom_addr[COS_ADDR_BITS-1 -: 2];
	assign rom_off = rom_addr[COS_ADDR_BITS-3:0];
	assign rom_idx = quad[0] ? (QI_W'(QUARTER) - {1'b0, rom_off}) : {1'b0, rom_off};
	assign cos_mag = cos_tab[rom_idx];
	assign cos_val = (quad[1] ^ quad[0]) ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});

	// Mixer with rounding to the sample scale.
	assign mix_prod = sample_q * cos_q;
	assign mix_round = mix_prod + (2*cam_pkg::SAMPLE_W)'(16384);

	// Recovered value: four times the baseband average less the carrier amplitude.
	assign rec_wide = $signed({{2{avg_q[cam_pkg::AVG_W-1]}}, avg_q, 2'b00})
		- $signed({{(REC_W-cam_pkg::AMP_W){1'b0}}, amplitude_q});

	// Moving averages.
	assign car_start = (state_q == ST_CAR_GO);
	assign sm_start = (state_q == ST_SM_GO);

	cam_mavg #(
		.LINE_W  (cam_pkg::SAMPLE_W),
		.SUM_W   (CAR_W),
		.MAX_TAPS(MAX_TAPS)
	) u_car (
		.clk   (clk),
		.arst_n(arst_n),
		.start (car_start),
		.x     (mix_q),
		.taps  (carrier_taps_q),
		.sum   (car_sum),
		.count (car_count),
		.done  (car_done)
	);

	cam_mavg #(
		.LINE_W  (cam_pkg::DEM_W),
		.SUM_W   (SM_W),
		.MAX_TAPS(MAX_TAPS)
	) u_sm (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sm_start),
		.x     (rec_q),
		.taps  (smooth_taps_q),
		.sum   (sm_sum),
		.count (sm_count),
		.done  (sm_done)
	);

	// Shared divider: running sum over the fill count for either average.
	assign div_start = ((state_q == ST_CAR_WAIT) && car_done) ||
		((state_q == ST_SM_WAIT) && sm_done);
	assign div_num = (state_q == ST_CAR_WAIT) ? DIV_W'(car_sum) : DIV_W'(sm_sum);
	assign div_den = (state_q == ST_CAR_WAIT) ? car_count : sm_count;

	cam_div #(
		.NUM_W(DIV_W),
		.DEN_W(CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_num),
		.divisor (div_den),
		.quotient(div_quo),
		.done    (div_done)
	);

	// Output word valid: set when a result is pushed, cleared when the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_PUSH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_ROM;
					end
				end
				ST_ROM: begin
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					state_q <= ST_CAR_GO;
				end
				ST_CAR_GO: begin
					state_q <= ST_CAR_WAIT;
				end
				ST_CAR_WAIT: begin
					if (car_done) begin
						state_q <= ST_CAR_DIV;
					end
				end
				ST_CAR_DIV: begin
					if (div_done) begin
						state_q <= ST_REC;
					end
				end
				ST_REC: begin
					state_q <= ST_SM_GO;
				end
				ST_SM_GO: begin
					state_q <= ST_SM_WAIT;
				end
				ST_SM_WAIT: begin
					if (sm_done) begin
						state_q <= ST_SM_DIV;
					end
				end
				ST_SM_DIV: begin
					if (div_done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers loaded by the sequencer.
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_ch.sample;
			phase_q <= phase_prod;
		end
		if (state_q == ST_ROM) begin
			cos_q <= cos_val;
		end
		if (state_q == ST_MIX) begin
			mix_q <= mix_round[2*cam_pkg::SAMPLE_W-2 -: cam_pkg::SAMPLE_W];
		end
		if ((state_q == ST_CAR_DIV) && div_done) begin
			if (div_quo > AVG_HI) begin
				avg_q <= cam_pkg::AVG_W'(AVG_HI);
			end else if (div_quo < AVG_LO) begin
				avg_q <= cam_pkg::AVG_W'(AVG_LO);
			end else begin
				avg_q <= cam_pkg::AVG_W'(div_quo);
			end
		end
		if (state_q == ST_REC) begin
			if (rec_wide > REC_HI) begin
				rec_q <= cam_pkg::DEM_W'(REC_HI);
			end else if (rec_wide < REC_LO) begin
				rec_q <= cam_pkg::DEM_W'(REC_LO);
			end else begin
				rec_q <= cam_pkg::DEM_W'(rec_wide);
			end
		end
		if ((state_q == ST_SM_DIV) && div_done) begin
			if (div_quo > DEM_HI) begin
				dem_q <= cam_pkg::DEM_W'(DEM_HI);
			end else if (div_quo < DEM_LO) begin
				dem_q <= cam_pkg::DEM_W'(DEM_LO);
			end else begin
				dem_q <= cam_pkg::DEM_W'(div_quo);
			end
		end
		if ((state_q == ST_PUSH) && out_free) begin
			out_avg_q <= avg_q;
			out_dem_q <= dem_q;
		end
	end

	// Result word.
	assign result_ch.valid = out_valid_q;
	assign result_ch.baseband_avg = out_avg_q;
	assign result_ch.demodulated = out_dem_q;

endmodule

[sim/cam_demod_check.sv]
`timescale 1ns / 1ps
// Result checker for the AM demodulator: predicts each accepted sample word and compares results.
module cam_demod_check #(
	parameter int MAX_TAPS      = 64,
	parameter int COS_ADDR_BITS = 10
) (
	input  logic  clk,
	input  logic  arst_n,
	cam_sample_if sample_ch,
	cam_result_if result_ch,
	cam_cfg_if    cfg_ch,
	output int    mismatches,
	output int    pending_words
);
	import cam_pkg::*;

	typedef longint unsigned uq_t;

	typedef struct packed {
		logic signed [AVG_W-1:0] baseband_avg;
		logic signed [DEM_W-1:0] demodulated;
	} demod_word_t;

	localparam int  QUARTER     = 1 << (COS_ADDR_BITS - 2);
	localparam uq_t PI_HALF_Q30 = 64'd1686629713;
	localparam uq_t UNIT_Q30    = 64'd1073741824;
	localparam int  CARRIER     = 0;
	localparam int  SMOOTH      = 1;

	// Local copy of the configuration registers.
	logic [PHASE_W-1:0] phase_step_q;
	logic [AMP_W-1:0]   amplitude_q;
	logic [TAPS_W-1:0]  carrier_taps_q;
	logic [TAPS_W-1:0]  smooth_taps_q;

	// Both moving averages: delay lines, running sums, write positions and fill counts.
	longint      win_line [2][MAX_TAPS];
	longint      win_sum [2];
	int unsigned win_pos [2];
	int unsigned win_count [2];

	longint      cos_tab [0:QUARTER];
	demod_word_t expected_words [$];
	int          fail_total;

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// First-quadrant cosine in Q1.15 from a Q30 Taylor series with truncating steps.
	function automatic longint quarter_cos(input int r);
		uq_t    th;
		uq_t    t2;
		uq_t    term;
		longint acc;
		th = (PI_HALF_Q30 * uq_t'(r)) >> (COS_ADDR_BITS - 2);
		t2 = (th * th) >> 30;
		term = UNIT_Q30;
		acc = longint'(UNIT_Q30);
		for (int k = 1; k <= 8; k++) begin
			term = ((term * t2) >> 30) / uq_t'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		acc = clamp(acc, 0, longint'(UNIT_Q30));
		return longint'((uq_t'(acc) * 64'd32767 + 64'd536870912) >> 30);
	endfunction

	// Full-circle cosine: odd quadrants mirror the offset, the middle two negate.
	function automatic longint cos_lookup(input logic [PHASE_W-1:0] phase);
		logic [COS_ADDR_BITS-1:0] addr;
		logic [1:0]               quad;
		int                       off;
		longint                   mag;
		addr = phase[PHASE_W-1 -: COS_ADDR_BITS];
		quad = addr[COS_ADDR_BITS-1 -: 2];
		off = int'(addr[COS_ADDR_BITS-3:0]);
		mag = quad[0] ? cos_tab[QUARTER - off] : cos_tab[off];
		return (quad[0] ^ quad[1]) ? -mag : mag;
	endfunction

	// One step of a moving average; the sum always covers the whole line.
	function automatic longint run_average(input int f, input int unsigned taps_reg,
			input longint x);
		int unsigned taps;
		int unsigned p;
		taps = (taps_reg == 0) ? 1 : ((taps_reg > MAX_TAPS) ? MAX_TAPS : taps_reg);
		p = win_pos[f] % MAX_TAPS;
		if (win_count[f] < taps) begin
			win_count[f] = win_count[f] + 1;
		end
		win_sum[f] = win_sum[f] - win_line[f][p] + x;
		win_line[f][p] = x;
		win_pos[f] = (p + 1 >= taps) ? 0 : p + 1;
		return win_sum[f] / longint'(win_count[f]);
	endfunction

	// Mixer, carrier average, scaling and smoothing for one sample word.
	function automatic demod_word_t predict_word(input logic signed [SAMPLE_W-1:0] s,
			input logic [INDEX_W-1:0] idx);
		logic [PHASE_W-1:0] phase;
		longint             mix;
		longint             avg;
		longint             rec;
		longint             dem;
		demod_word_t        w;
		phase = idx * phase_step_q;
		mix = (longint'(s) * cos_lookup(phase) + 64'sd16384) >>> 15;
		avg = clamp(run_average(CARRIER, int'(carrier_taps_q), mix), -32768, 32767);
		rec = clamp(4 * avg - longint'(amplitude_q), -131072, 131071);
		dem = clamp(run_average(SMOOTH, int'(smooth_taps_q), rec), -131072, 131071);
		w.baseband_avg = AVG_W'(avg);
		w.demodulated = DEM_W'(dem);
		return w;
	endfunction

	initial begin
		for (int r = 0; r <= QUARTER; r++) begin
			cos_tab[r] = quarter_cos(r);
		end
	end

	// Watch the three channels: registers, then results, then new sample words.
	always @(posedge clk or negedge arst_n) begin : watch
		demod_word_t want;
		if (!arst_n) begin
			phase_step_q = PHASE_STEP_RST;
			amplitude_q = AMPLITUDE_RST;
			carrier_taps_q = CARRIER_TAPS_RST;
			smooth_taps_q = SMOOTH_TAPS_RST;
			for (int f = 0; f < 2; f++) begin
				for (int i = 0; i < MAX_TAPS; i++) begin
					win_line[f][i] = 0;
				end
				win_sum[f] = 0;
				win_pos[f] = 0;
				win_count[f] = 0;
			end
			expected_words.delete();
			fail_total = 0;
			mismatches <= 0;
			pending_words <= 0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_PHASE_STEP:   phase_step_q = cfg_ch.data[PHASE_W-1:0];
					REG_AMPLITUDE:    amplitude_q = cfg_ch.data[AMP_W-1:0];
					REG_CARRIER_TAPS: carrier_taps_q = cfg_ch.data[TAPS_W-1:0];
					REG_SMOOTH_TAPS:  smooth_taps_q = cfg_ch.data[TAPS_W-1:0];
					default: ;
				endcase
			end

			if (result_ch.valid && result_ch.ready) begin
				if (expected_words.size() == 0) begin
					fail_total++;
					$display("%0t: result word with nothing expected, actual avg %0d dem %0d",
						$time, $signed(result_ch.baseband_avg),
						$signed(result_ch.demodulated));
				end else begin
					want = expected_words.pop_front();
					if (result_ch.baseband_avg !== want.baseband_avg) begin
						fail_total++;
						$display("%0t: baseband_avg mismatch, expected %0d, actual %0d",
							$time, $signed(want.baseband_avg),
							$signed(result_ch.baseband_avg));
					end
					if (result_ch.demodulated !== want.demodulated) begin
						fail_total++;
						$display("%0t: demodulated mismatch, expected %0d, actual %0d",
							$time, $signed(want.demodulated),
							$signed(result_ch.demodulated));
					end
				end
			end

			if (sample_ch.valid && sample_ch.ready) begin
				expected_words.push_back(predict_word(sample_ch.sample, sample_ch.sample_index));
			end

			mismatches <= fail_total;
			pending_words <= expected_words.size();
		end
	end

endmodule

[sim/tb_coherent_am_demodulator_core.sv]
`timescale 1ns / 1ps
// Testbench top for the AM demodulator: clock, reset, stimulus, result pacing and verdict.
module tb_coherent_am_demodulator_core;
	import cam_pkg::*;

	localparam int CYCLE_LIMIT     = 1000000;
	localparam int DRAIN_CYCLES    = 60;
	localparam int WORDS_PER_PHASE = 135;
	localparam int RANDOM_PHASES   = 9;

	// Indexes that match no register; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_PAST_END = REG_SMOOTH_TAPS + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_IDX  = '1;

	logic               clk;
	logic               arst_n;
	int                 mismatches;
	int                 pending_words;
	int                 cycle_count;
	logic [INDEX_W-1:0] next_index;

	cam_sample_if sample_ch ();
	cam_result_if result_ch ();
	cam_cfg_if    cfg_ch ();

	coherent_am_demodulator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg       (cfg_ch)
	);

	cam_demod_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_ch     (sample_ch),
		.result_ch     (result_ch),
		.cfg_ch        (cfg_ch),
		.mismatches    (mismatches),
		.pending_words (pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop if the block hangs.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// Idle gap length: mostly short, now and then long.
	function automatic int pick_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			return 0;
		end else if (pick < 80) begin
			return $urandom_range(1, 3);
		end else if (pick < 96) begin
			return $urandom_range(4, 20);
		end else begin
			return $urandom_range(30, 50);
		end
	endfunction

	// Tap register value, including zero and values past the line length.
	function automatic logic [CFG_DATA_W-1:0] pick_taps();
		int pick;
		int taps;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			taps = 0;
		end else if (pick < 20) begin
			taps = $urandom_range(65, 127);
		end else if (pick < 60) begin
			taps = $urandom_range(1, 8);
		end else begin
			taps = $urandom_range(9, 64);
		end
		// Junk in the unused upper bits must be dropped by the register.
		return ({$urandom()} & 32'hFFFF_FF80) | CFG_DATA_W'(taps);
	endfunction

	// Pace the result side: ready runs and stalls of random length.
	initial begin
		result_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			result_ch.ready <= 1'b1;
			repeat (($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(20, 200))
				@(posedge clk);
			result_ch.ready <= 1'b0;
			repeat (pick_gap() + 1) @(posedge clk);
		end
	end

	task automatic wait_idle();
		do @(posedge clk); while (pending_words != 0);
	endtask

	// Present one sample word after an optional gap and hold it until it is taken.
	task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic [INDEX_W-1:0] idx,
			input int gap);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= s;
		sample_ch.sample_index <= idx;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	// Write one register; valid is left high so writes can follow back to back.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cfg_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// Mostly a continuous stream of indexes, with jumps and indexes near the wrap as noise.
	task automatic send_random(input int count);
		int                         pick;
		bit                         steady;
		logic [INDEX_W-1:0]         idx;
		logic signed [SAMPLE_W-1:0] s;
		steady = ($urandom_range(0, 3) == 0);
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				idx = next_index;
			end else if (pick < 90) begin
				idx = $urandom();
			end else begin
				idx = 32'hFFFF_FFF0 + $urandom_range(0, 15);
			end
			next_index = idx + 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				s = pick[0] ? 16'sh7FFF : 16'sh8000;
			end else if (pick < 25) begin
				s = SAMPLE_W'($urandom_range(0, 200) - 100);
			end else begin
				s = SAMPLE_W'($urandom());
			end
			send_word(s, idx, steady ? 0 : pick_gap());
		end
		sample_ch.valid <= 1'b0;
		wait_idle();
	endtask

	initial begin
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		sample_ch.sample_index = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		next_index = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset settings: field extremes and carrier peaks.
		send_word(16'sh7FFF, 32'd0, 0);
		send_word(16'sh8000, 32'd0, 1);
		send_word(16'sh0000, 32'hFFFF_FFFF, 0);
		send_word(16'sh8000, 32'hFFFF_FFFF, 2);
		// Half a carrier period in: the cosine sits at its negative peak.
		send_word(16'sh7FFF, 32'd5, 0);
		send_word(16'sh8000, 32'd5, 0);
		send_word(16'sh5555, 32'd3, 3);
		send_word(16'shAAAA, 32'd8, 0);
		send_word(16'sh0001, 32'd1, 0);
		send_word(16'shFFFF, 32'd2, 0);
		// Fill both lines past their tap counts with alternating extremes.
		for (int n = 6; n < 20; n++) begin
			send_word(n[0] ? 16'sh7FFF : 16'sh8000, n, pick_gap());
		end
		sample_ch.valid <= 1'b0;
		wait_idle();

		// Smallest settings; a write past the register list must change nothing.
		write_reg(REG_PHASE_STEP, 32'h0000_0000);
		write_reg(REG_AMPLITUDE, 32'h0000_0000);
		write_reg(REG_CARRIER_TAPS, 32'd1);
		write_reg(REG_SMOOTH_TAPS, 32'd1);
		write_reg(REG_PAST_END, 32'hFFFF_FFFF);
		cfg_ch.valid <= 1'b0;
		send_random(WORDS_PER_PHASE);

		// Largest settings; the recovered value saturates with a full amplitude.
		write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
		write_reg(REG_AMPLITUDE, 32'hFFFF_FFFF);
		write_reg(REG_CARRIER_TAPS, 32'd64);
		write_reg(REG_SMOOTH_TAPS, 32'd64);
		cfg_ch.valid <= 1'b0;
		send_random(WORDS_PER_PHASE);

		// Taps shrink while the lines are full: zero acts as one, too large acts as the maximum.
		write_reg(REG_PHASE_STEP, 32'h8000_0000);
		write_reg(REG_CARRIER_TAPS, 32'd0);
		write_reg(REG_SMOOTH_TAPS, 32'd127);
		write_reg(REG_TOP_IDX, 32'h0000_0000);
		cfg_ch.valid <= 1'b0;
		send_random(WORDS_PER_PHASE);

		write_reg(REG_CARRIER_TAPS, 32'd65);
		write_reg(REG_SMOOTH_TAPS, 32'hFFFF_FF80);
		write_reg(REG_AMPLITUDE, 32'h0000_4000);
		cfg_ch.valid <= 1'b0;
		send_random(WORDS_PER_PHASE);

		// Back to the reset values.
		write_reg(REG_PHASE_STEP, 32'(PHASE_STEP_RST));
		write_reg(REG_AMPLITUDE, 32'(AMPLITUDE_RST));
		write_reg(REG_CARRIER_TAPS, 32'(CARRIER_TAPS_RST));
		write_reg(REG_SMOOTH_TAPS, 32'(SMOOTH_TAPS_RST));
		cfg_ch.valid <= 1'b0;
		send_random(WORDS_PER_PHASE);

		// Random settings, each register rewritten now and then.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if ($urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 1) == 0) begin
					write_reg(REG_PHASE_STEP, $urandom());
				end else begin
					write_reg(REG_PHASE_STEP, 32'(64'h1_0000_0000 / $urandom_range(2, 64)));
				end
			end
			if ($urandom_range(0, 3) != 0) begin
				write_reg(REG_AMPLITUDE, $urandom());
			end
			if ($urandom_range(0, 3) != 0) begin
				write_reg(REG_CARRIER_TAPS, pick_taps());
			end
			if ($urandom_range(0, 3) != 0) begin
				write_reg(REG_SMOOTH_TAPS, pick_taps());
			end
			if ($urandom_range(0, 7) == 0) begin
				write_reg(CFG_IDX_W'($urandom_range(4, 255)), $urandom());
			end
			cfg_ch.valid <= 1'b0;
			send_random(WORDS_PER_PHASE);
		end

		// Let any stray result words show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_words == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
